// ----- sv/vcrf_pkg.sv -----
`default_nettype none
package vcrf_pkg;
  localparam int unsigned MirrorWords    = 2048;
  localparam int unsigned PaletteEntries = 256;
  localparam logic [31:0] WindowBaseDef  = 32'd3141632;
  localparam logic [31:0] AreaBytes      = 32'h0000_1000;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PAL   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  // spare size code, handled as a word
  localparam logic [1:0] SIZE_WIDE = 2'd3;

  localparam logic [11:0] OFF_BEAM0   = 12'h004;
  localparam logic [11:0] OFF_BEAM1   = 12'h006;
  localparam logic [11:0] OFF_COPDANG = 12'h02E;
  localparam logic [11:0] OFF_COPPTR  = 12'h080;
  localparam logic [11:0] OFF_WIN0    = 12'h08E;
  localparam logic [11:0] OFF_WIN1    = 12'h090;
  localparam logic [11:0] OFF_WIN2    = 12'h092;
  localparam logic [11:0] OFF_WIN3    = 12'h094;
  localparam logic [11:0] OFF_BPLPTR  = 12'h0E0;
  localparam logic [11:0] OFF_BPL0    = 12'h100;
  localparam logic [11:0] OFF_BPL1    = 12'h102;
  localparam logic [11:0] OFF_BPL2    = 12'h104;
  localparam logic [11:0] OFF_MOD0    = 12'h108;
  localparam logic [11:0] OFF_MOD1    = 12'h10A;
  localparam logic [11:0] OFF_BPL4    = 12'h10C;
  localparam logic [11:0] OFF_SPRPTR  = 12'h120;
  localparam logic [11:0] OFF_SPRPTR_END = 12'h140;

  localparam logic [11:0] OFF_DMA   = 12'h096;
  localparam logic [11:0] OFF_IENA  = 12'h09A;
  localparam logic [11:0] OFF_IREQ  = 12'h09C;
  localparam logic [11:0] OFF_ADK   = 12'h09E;
  localparam logic [11:0] OFF_JUMP1 = 12'h088;
  localparam logic [11:0] OFF_JUMP2 = 12'h08A;
  localparam logic [11:0] OFF_BPL3  = 12'h106;
  localparam logic [11:0] COLOR_FIRST = 12'h180;

  localparam logic [1:0] JUMP_NONE = 2'd0;
  localparam logic [1:0] JUMP_ONE  = 2'd1;
  localparam logic [1:0] JUMP_TWO  = 2'd2;

  localparam logic [15:0] SETCLR_FLAG  = 16'h8000;
  localparam logic [15:0] LOW_NIB_SEL  = 16'h0200;
endpackage
`default_nettype wire

// ----- sv/vcrf_ram.sv -----
`default_nettype none
module vcrf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/video_chipset_register_file_core.sv -----
`default_nettype none
// Bus-facing register block of a video chipset.
// Slave stream s_axis_*: one access item (kind, offset, size, data, palette
// index). Master stream m_axis_*: exactly one result item per access item.
// State: a 16-bit register mirror and a 24-bit palette, both in synchronous
// RAMs, plus dedicated set/clear, pointer and control registers in flops.
// Each item, of every kind and size, passes through the states ST_RD0,
// ST_RD1 and ST_EXEC between acceptance and a valid result: read the
// addressed mirror word, then write back the merged first half while
// reading the next word, then write the second half of a word access and
// the palette entry and register the result. No new item is taken until
// the result has left the single output register and the block is idle.
// After reset a clearing pass writes zero to all mirror words and palette
// entries, one per cycle, while s_axis_tready stays low. When the receiver
// stalls, the result is held in the output register and no new item is
// taken until it is delivered.
module video_chipset_register_file_core
  import vcrf_pkg::*;
#(
  parameter logic [31:0] WINDOW_BASE = WindowBaseDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // bus_offset[31:0], access_size[33:32], write_value[65:34],
  // palette_index[73:66], zero fill[79:74]
  input  wire logic [79:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[31:0], palette_color[55:32], zero fill[63:56]
  output logic      [63:0] m_axis_tdata,
  // copper_jump[1:0]
  output logic      [1:0]  m_axis_tuser
);
  localparam int unsigned MA = $clog2(MirrorWords);
  localparam int unsigned PA = $clog2(PaletteEntries);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_EXEC, ST_OUT
  } state_t;

  state_t state;
  logic [MA-1:0] clr_cnt;

  // latched item
  logic [1:0]  kind;
  logic [31:0] bus;
  logic [1:0]  size;
  logic [31:0] wv;
  logic [PA-1:0] pidx;
  logic        in_win;
  logic [11:0] off;
  logic [MA-1:0] idx;
  logic [15:0] cur_word;

  // dedicated registers
  logic [15:0] dma_control, interrupt_enable, interrupt_request, audio_disk_control;
  logic [15:0] bpl_con [5];
  logic [15:0] bpl_mod [2];
  logic [15:0] win_fetch [4];
  logic [15:0] copper_danger;
  logic [31:0] cop_ptr [2];
  logic [31:0] bpl_ptr [8];
  logic [31:0] spr_ptr [8];

  // RAM ports
  logic          m_we;
  logic [MA-1:0] m_waddr, m_raddr;
  logic [15:0]   m_wdata, m_rdata;
  logic          p_we;
  logic [PA-1:0] p_waddr, p_raddr;
  logic [23:0]   p_wdata, p_rdata;

  vcrf_ram #(.Width(16), .Depth(MirrorWords)) u_mirror (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );
  vcrf_ram #(.Width(24), .Depth(PaletteEntries)) u_palette (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // decode of the latched offset
  logic        word;
  logic        last_word;
  logic [15:0] v16;
  logic        is_setclr, is_plain, is_ptr, is_color;
  logic [15:0] special_val;
  logic        use_special;
  logic [31:0] rel;

  assign rel  = s_axis_tdata[31:0] - WINDOW_BASE;
  assign word = size[1];
  assign last_word = (idx == MA'(MirrorWords - 1));
  assign v16  = wv[15:0];
  assign is_setclr = (off == OFF_DMA) || (off == OFF_IENA) ||
                     (off == OFF_IREQ) || (off == OFF_ADK);
  assign is_color = (off >= COLOR_FIRST) && (off < COLOR_FIRST + 12'h040);
  assign is_ptr = !off[0] && (((off >= OFF_COPPTR) && (off < OFF_JUMP1)) ||
                  ((off >= OFF_BPLPTR) && (off < OFF_BPL0)) ||
                  ((off >= OFF_SPRPTR) && (off < OFF_SPRPTR_END)));

  // pick the dedicated read value
  always_comb begin
    logic [31:0] p;
    p = '0;
    is_plain = 1'b1;
    special_val = '0;
    unique case (off)
      OFF_BPL0: special_val = bpl_con[0];
      OFF_BPL1: special_val = bpl_con[1];
      OFF_BPL2: special_val = bpl_con[2];
      OFF_BPL3: special_val = bpl_con[3];
      OFF_BPL4: special_val = bpl_con[4];
      OFF_MOD0: special_val = bpl_mod[0];
      OFF_MOD1: special_val = bpl_mod[1];
      OFF_WIN0: special_val = win_fetch[0];
      OFF_WIN1: special_val = win_fetch[1];
      OFF_WIN2: special_val = win_fetch[2];
      OFF_WIN3: special_val = win_fetch[3];
      OFF_COPDANG: special_val = copper_danger;
      default: is_plain = 1'b0;
    endcase
    if (off >= OFF_SPRPTR) p = spr_ptr[off[4:2]];
    else if (off >= OFF_BPLPTR) p = bpl_ptr[off[4:2]];
    else p = cop_ptr[off[2]];
    unique case (off)
      OFF_DMA:  special_val = dma_control;
      OFF_IENA: special_val = interrupt_enable;
      OFF_IREQ: special_val = interrupt_request;
      OFF_ADK:  special_val = audio_disk_control;
      default: begin
        if (!is_plain && is_ptr) special_val = off[1] ? p[15:0] : p[31:16];
        else if (!is_plain) special_val = '0;
      end
    endcase
    use_special = is_setclr || is_plain || is_ptr ||
                  (off == OFF_BEAM0) || (off == OFF_BEAM1);
  end

  logic [15:0] sc_next;
  always_comb begin
    logic [15:0] cur;
    unique case (off)
      OFF_DMA:  cur = dma_control;
      OFF_IENA: cur = interrupt_enable;
      OFF_IREQ: cur = interrupt_request;
      default:  cur = audio_disk_control;
    endcase
    sc_next = (v16 & SETCLR_FLAG) != 16'h0 ? (cur | {1'b0, v16[14:0]})
                                            : (cur & ~{1'b0, v16[14:0]});
  end

  // colour write data
  logic [23:0] col_new;
  always_comb begin
    if ((bpl_con[3] & LOW_NIB_SEL) != 16'h0)
      col_new = {p_rdata[23:20], v16[11:8], p_rdata[15:12], v16[7:4],
                 p_rdata[7:4], v16[3:0]};
    else
      col_new = {v16[11:8], v16[11:8], v16[7:4], v16[7:4], v16[3:0], v16[3:0]};
  end

  // merge the first half into the addressed word as it leaves the RAM
  logic [15:0] first_wr;
  always_comb begin
    unique case (size)
      SIZE_BYTE: first_wr = bus[0] ? {wv[7:0], m_rdata[7:0]}
                                   : {m_rdata[15:8], wv[7:0]};
      SIZE_HALF: first_wr = v16;
      default:   first_wr = wv[31:16];
    endcase
  end

  logic [15:0] rv;
  assign rv = use_special ? special_val : cur_word;

  // shape the result fields
  logic [31:0] rd_val;
  logic [1:0]  jump_val;
  always_comb begin
    rd_val = '0;
    jump_val = JUMP_NONE;
    if (kind == KIND_READ && in_win && off != OFF_JUMP1 && off != OFF_JUMP2) begin
      case (size)
        SIZE_BYTE: rd_val = {24'h0, bus[0] ? rv[15:8] : rv[7:0]};
        SIZE_HALF: rd_val = {16'h0, rv};
        default:   rd_val = {rv, last_word ? 16'h0 : m_rdata};
      endcase
    end
    if (kind == KIND_WRITE && in_win) begin
      if (off == OFF_JUMP1) jump_val = JUMP_ONE;
      else if (off == OFF_JUMP2) jump_val = JUMP_TWO;
    end
  end

  // RAM port drive
  always_comb begin
    m_we = 1'b0; m_waddr = idx; m_wdata = first_wr; m_raddr = idx;
    p_we = 1'b0; p_waddr = {bpl_con[3][15:13], off[5:1]}; p_wdata = col_new;
    p_raddr = (kind == KIND_PAL) ? pidx : {bpl_con[3][15:13], off[5:1]};
    unique case (state)
      ST_CLEAR: begin
        m_we = 1'b1; m_waddr = clr_cnt; m_wdata = '0;
        p_we = 1'b1; p_waddr = clr_cnt[PA-1:0]; p_wdata = '0;
      end
      ST_RD1: begin
        m_raddr = idx + MA'(1);
        if (kind == KIND_WRITE && in_win) begin
          m_we = 1'b1;
        end
      end
      ST_EXEC: begin
        if (kind == KIND_WRITE && in_win && word && !last_word) begin
          m_we = 1'b1; m_waddr = idx + MA'(1); m_wdata = v16;
        end
        if (kind == KIND_WRITE && in_win && is_color && !is_setclr && !is_plain
            && !is_ptr) begin
          p_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  // sequencer, dedicated registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      m_axis_tvalid <= 1'b0;
      dma_control <= '0; interrupt_enable <= '0;
      interrupt_request <= '0; audio_disk_control <= '0;
      copper_danger <= '0;
      for (int i = 0; i < 5; i++) bpl_con[i] <= '0;
      for (int i = 0; i < 2; i++) bpl_mod[i] <= '0;
      for (int i = 0; i < 4; i++) win_fetch[i] <= '0;
      for (int i = 0; i < 2; i++) cop_ptr[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        bpl_ptr[i] <= '0; spr_ptr[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + MA'(1);
          if (clr_cnt == MA'(MirrorWords - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind   <= s_axis_tuser;
            bus    <= s_axis_tdata[31:0];
            size   <= s_axis_tdata[33:32];
            wv     <= s_axis_tdata[65:34];
            pidx   <= s_axis_tdata[73:66];
            in_win <= (s_axis_tdata[31:0] >= WINDOW_BASE) && (rel < AreaBytes);
            off    <= rel[11:0];
            idx    <= rel[11:1];
            state  <= ST_RD0;
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          cur_word <= m_rdata;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          m_axis_tdata <= {8'h0, (kind == KIND_PAL) ? p_rdata : 24'h0, rd_val};
          m_axis_tuser <= jump_val;
          if (kind == KIND_WRITE && in_win) begin
            if (is_setclr) begin
              unique case (off)
                OFF_DMA:  dma_control <= sc_next;
                OFF_IENA: interrupt_enable <= sc_next;
                OFF_IREQ: interrupt_request <= sc_next;
                default:  audio_disk_control <= sc_next;
              endcase
            end else if (is_plain) begin
              unique case (off)
                OFF_BPL0: bpl_con[0] <= v16;
                OFF_BPL1: bpl_con[1] <= v16;
                OFF_BPL2: bpl_con[2] <= v16;
                OFF_BPL3: bpl_con[3] <= v16;
                OFF_BPL4: bpl_con[4] <= v16;
                OFF_MOD0: bpl_mod[0] <= v16;
                OFF_MOD1: bpl_mod[1] <= v16;
                OFF_WIN0: win_fetch[0] <= v16;
                OFF_WIN1: win_fetch[1] <= v16;
                OFF_WIN2: win_fetch[2] <= v16;
                OFF_WIN3: win_fetch[3] <= v16;
                default: copper_danger <= v16;
              endcase
            end else if (is_ptr) begin
              if (off >= OFF_SPRPTR) begin
                if (off[1]) spr_ptr[off[4:2]][15:0] <= v16;
                else if (word) spr_ptr[off[4:2]] <= wv;
                else spr_ptr[off[4:2]][31:16] <= v16;
              end else if (off >= OFF_BPLPTR) begin
                if (off[1]) bpl_ptr[off[4:2]][15:0] <= v16;
                else if (word) bpl_ptr[off[4:2]] <= wv;
                else bpl_ptr[off[4:2]][31:16] <= v16;
              end else begin
                if (off[1]) cop_ptr[off[2]][15:0] <= v16;
                else if (word) cop_ptr[off[2]] <= wv;
                else cop_ptr[off[2]][31:16] <= v16;
              end
            end
          end
          m_axis_tvalid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/video_chipset_register_file_core_chk.sv -----
`timescale 1ns / 1ps
module video_chipset_register_file_core_chk
  import vcrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_valid,
  input  wire logic        s_ready,
  input  wire logic [79:0] s_data,
  input  wire logic [1:0]  s_user,
  input  wire logic        m_valid,
  input  wire logic        m_ready,
  input  wire logic [63:0] m_data,
  input  wire logic [1:0]  m_user,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic [31:0] rd;
    logic [23:0] col;
    logic [1:0]  jump;
  } access_result_t;

  logic [15:0] mirror [MirrorWords];
  logic [23:0] palette [PaletteEntries];
  logic [15:0] dmacon, intena, intreq, adkcon, copcon;
  logic [15:0] bplcon [5];
  logic [15:0] bplmod [2];
  logic [15:0] winfetch [4];
  logic [31:0] coplc [2];
  logic [31:0] bplpt [8];
  logic [31:0] sprpt [8];
  access_result_t awaited [$];

  // Return a handle number for the plain 16-bit register at an offset, or -1
  function automatic int plain_id(logic [11:0] off);
    case (off)
      OFF_BPL0: return 0;
      OFF_BPL1: return 1;
      OFF_BPL2: return 2;
      OFF_BPL3: return 3;
      OFF_BPL4: return 4;
      OFF_MOD0: return 5;
      OFF_MOD1: return 6;
      OFF_WIN0: return 7;
      OFF_WIN1: return 8;
      OFF_WIN2: return 9;
      OFF_WIN3: return 10;
      OFF_COPDANG: return 11;
      default: return -1;
    endcase
  endfunction

  function automatic logic [15:0] plain_get(int id);
    if (id < 5) return bplcon[id];
    if (id < 7) return bplmod[id-5];
    if (id < 11) return winfetch[id-7];
    return copcon;
  endfunction

  // Pointer: 0..1 copper, 2..9 bitplane, 10..17 sprite; -1 none
  function automatic int ptr_id(logic [11:0] off);
    if (off[0]) return -1;
    if (off >= OFF_COPPTR && off < OFF_JUMP1) return int'((off - OFF_COPPTR) >> 2);
    if (off >= OFF_BPLPTR && off < OFF_BPL0) return 2 + int'((off - OFF_BPLPTR) >> 2);
    if (off >= OFF_SPRPTR && off < OFF_SPRPTR_END)
      return 10 + int'((off - OFF_SPRPTR) >> 2);
    return -1;
  endfunction

  function automatic logic [31:0] ptr_get(int id);
    if (id < 2) return coplc[id];
    if (id < 10) return bplpt[id-2];
    return sprpt[id-10];
  endfunction

  function automatic logic [15:0] setclr(logic [15:0] cur, logic [15:0] v);
    return v[15] ? (cur | {1'b0, v[14:0]}) : (cur & ~{1'b0, v[14:0]});
  endfunction

  // Apply a write to the predicted state; returns the copper jump strobe
  task automatic apply_write(logic [31:0] bus, logic [1:0] sz, logic [31:0] v,
                             output logic [1:0] jump);
    logic [31:0] rel;
    logic [11:0] off;
    logic [10:0] idx;
    logic [15:0] v16;
    logic [31:0] p;
    logic [3:0] r4, g4, b4;
    logic [7:0] entry;
    logic [23:0] c;
    int id;
    jump = JUMP_NONE;
    rel = bus - WindowBaseDef;
    if (bus < WindowBaseDef || rel >= AreaBytes) return;
    off = rel[11:0];
    idx = off[11:1];
    v16 = v[15:0];
    if (sz == SIZE_BYTE) begin
      if (bus[0]) mirror[idx][15:8] = v[7:0];
      else mirror[idx][7:0] = v[7:0];
    end else if (sz == SIZE_HALF) begin
      mirror[idx] = v16;
    end else begin
      mirror[idx] = v[31:16];
      if (idx != 11'h7FF) mirror[idx+1] = v16;
    end
    if (off == OFF_DMA) dmacon = setclr(dmacon, v16);
    else if (off == OFF_IENA) intena = setclr(intena, v16);
    else if (off == OFF_IREQ) intreq = setclr(intreq, v16);
    else if (off == OFF_ADK) adkcon = setclr(adkcon, v16);
    else if (plain_id(off) >= 0) begin
      id = plain_id(off);
      if (id < 5) bplcon[id] = v16;
      else if (id < 7) bplmod[id-5] = v16;
      else if (id < 11) winfetch[id-7] = v16;
      else copcon = v16;
    end else if (ptr_id(off) >= 0) begin
      id = ptr_id(off);
      p = ptr_get(id);
      if (!off[1]) p = (sz >= SIZE_WORD) ? v : {v16, p[15:0]};
      else p = {p[31:16], v16};
      if (id < 2) coplc[id] = p;
      else if (id < 10) bplpt[id-2] = p;
      else sprpt[id-10] = p;
    end else if (off == OFF_JUMP1) jump = JUMP_ONE;
    else if (off == OFF_JUMP2) jump = JUMP_TWO;
    else if (off >= COLOR_FIRST && off < COLOR_FIRST + 12'h40) begin
      entry = {bplcon[3][15:13], 5'((off - COLOR_FIRST) >> 1)};
      r4 = v16[11:8];
      g4 = v16[7:4];
      b4 = v16[3:0];
      c = palette[entry];
      if ((bplcon[3] & LOW_NIB_SEL) != 0) c = {c[23:20], r4, c[15:12], g4, c[7:4], b4};
      else c = {r4, r4, g4, g4, b4, b4};
      palette[entry] = c;
    end
  endtask

  function automatic logic [31:0] read_value(logic [31:0] bus, logic [1:0] sz);
    logic [31:0] rel;
    logic [11:0] off;
    logic [10:0] idx;
    logic [15:0] val, nxt;
    logic [31:0] p;
    rel = bus - WindowBaseDef;
    if (bus < WindowBaseDef || rel >= AreaBytes) return 0;
    off = rel[11:0];
    idx = off[11:1];
    if (off == OFF_JUMP1 || off == OFF_JUMP2) return 0;
    if (off == OFF_DMA) val = dmacon;
    else if (off == OFF_IENA) val = intena;
    else if (off == OFF_IREQ) val = intreq;
    else if (off == OFF_ADK) val = adkcon;
    else if (plain_id(off) >= 0) val = plain_get(plain_id(off));
    else if (ptr_id(off) >= 0) begin
      p = ptr_get(ptr_id(off));
      val = off[1] ? p[15:0] : p[31:16];
    end else if (off == OFF_BEAM0 || off == OFF_BEAM1) val = 0;
    else val = mirror[idx];
    if (sz >= SIZE_WORD) begin
      nxt = (idx != 11'h7FF) ? mirror[idx+1] : 16'h0;
      return {val, nxt};
    end
    if (sz == SIZE_BYTE) return bus[0] ? {24'h0, val[15:8]} : {24'h0, val[7:0]};
    return {16'h0, val};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Predict on each accepted access item, compare each delivered result item
  always @(posedge clk) begin
    access_result_t e, g;
    logic [1:0] j;
    if (rst) begin
      foreach (mirror[i]) mirror[i] = 0;
      foreach (palette[i]) palette[i] = 0;
      dmacon = 0; intena = 0; intreq = 0; adkcon = 0; copcon = 0;
      foreach (bplcon[i]) bplcon[i] = 0;
      foreach (bplmod[i]) bplmod[i] = 0;
      foreach (winfetch[i]) winfetch[i] = 0;
      foreach (coplc[i]) coplc[i] = 0;
      foreach (bplpt[i]) bplpt[i] = 0;
      foreach (sprpt[i]) sprpt[i] = 0;
      awaited.delete();
      errors = 0;
    end else begin
      if (m_valid && m_ready) begin
        g = '{m_data[31:0], m_data[55:32], m_user};
        if (awaited.size() == 0) report_mismatch("unexpected item", 0, 0);
        else begin
          e = awaited.pop_front();
          if (g.rd !== e.rd) report_mismatch("read_data", g.rd, e.rd);
          if (g.col !== e.col) report_mismatch("palette_color", g.col, e.col);
          if (g.jump !== e.jump) report_mismatch("copper_jump", g.jump, e.jump);
        end
      end
      if (s_valid && s_ready) begin
        e = '0;
        if (s_user == KIND_WRITE) begin
          apply_write(s_data[31:0], s_data[33:32], s_data[65:34], j);
          e.jump = j;
        end else if (s_user == KIND_READ) e.rd = read_value(s_data[31:0], s_data[33:32]);
        else if (s_user == KIND_PAL) e.col = palette[s_data[73:66]];
        awaited.push_back(e);
      end
    end
    pending = awaited.size();
  end
endmodule

// ----- tb/video_chipset_register_file_core_tb.sv -----
`timescale 1ns / 1ps
module video_chipset_register_file_core_tb;
  import vcrf_pkg::*;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          errors, pending;
  int          send_idle, recv_stall, hold_off;
  int          quiet;

  video_chipset_register_file_core dut (.*);

  video_chipset_register_file_core_chk chk (
    .clk, .rst,
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .s_data(s_axis_tdata), .s_user(s_axis_tuser),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_data(m_axis_tdata), .m_user(m_axis_tuser),
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Offer one access item and hold it until it is taken
  task automatic send_access(logic [1:0] kind, logic [31:0] bus, logic [1:0] sz,
                             logic [31:0] v, logic [7:0] pal);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'h0, pal, v, sz, bus};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random;
    logic [31:0] bus, v;
    logic [11:0] off;
    int r;
    r = $urandom_range(99);
    // Decode-relevant offsets, the window top and anywhere in the window; some outside
    if (r < 30) off = OFF_COPPTR + 12'(2 * $urandom_range(95));
    else if (r < 40) off = COLOR_FIRST + 12'(2 * $urandom_range(31));
    else if (r < 45) off = 12'hFFE + 12'($urandom_range(1));
    else off = 12'($urandom_range(12'hFFF));
    bus = WindowBaseDef + off;
    if ($urandom_range(99) < 3) bus = WindowBaseDef - 1 - $urandom_range(3);
    else if ($urandom_range(99) < 3) bus = WindowBaseDef + AreaBytes + $urandom_range(3);
    else if ($urandom_range(99) < 2) bus = $urandom;
    if (off == OFF_BPL3 && $urandom_range(1)) v = {16'($urandom_range(65535)), 16'h0} |
                                                ($urandom & 32'hE200);
    else v = $urandom;
    r = $urandom_range(99);
    send_access(r < 50 ? KIND_WRITE : r < 85 ? KIND_READ : r < 97 ? KIND_PAL : KIND_NONE,
                bus, 2'($urandom_range(3)), v, 8'($urandom_range(255)));
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else if (quiet > 20000) begin
      $display("video_chipset_register_file_core_tb: errors");
      $finish;
    end else quiet <= quiet + 1;
  end

  initial begin
    int sent;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    // Directed: extremes, each kind and size, special offsets
    send_access(KIND_READ, WindowBaseDef + OFF_BPL0, SIZE_WORD, 0, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_DMA, SIZE_HALF, 32'h0000_FFFF, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_DMA, SIZE_HALF, 32'h0000_0F0F, 0);
    send_access(KIND_READ, WindowBaseDef + OFF_DMA, SIZE_HALF, 0, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_JUMP1, SIZE_HALF, 32'hFFFF_FFFF, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_JUMP2, SIZE_WORD, 32'h1234_5678, 0);
    send_access(KIND_READ, WindowBaseDef + OFF_JUMP1, SIZE_WORD, 0, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_BPLPTR, SIZE_WORD, 32'hDEAD_BEEF, 0);
    send_access(KIND_READ, WindowBaseDef + OFF_BPLPTR + 12'h002, SIZE_HALF, 0, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_BEAM0, SIZE_HALF, 32'hAAAA, 0);
    send_access(KIND_READ, WindowBaseDef + OFF_BEAM0, SIZE_WIDE, 0, 0);
    send_access(KIND_WRITE, WindowBaseDef + COLOR_FIRST + 12'h001, SIZE_BYTE, 32'h55, 0);
    send_access(KIND_WRITE, WindowBaseDef + COLOR_FIRST, SIZE_HALF, 32'h0ABC, 0);
    send_access(KIND_WRITE, WindowBaseDef + OFF_BPL3, SIZE_HALF, 32'hE200, 0);
    send_access(KIND_WRITE, WindowBaseDef + COLOR_FIRST + 12'h03E, SIZE_HALF, 32'h0FFF, 0);
    send_access(KIND_PAL, 0, SIZE_BYTE, 0, 8'd0);
    send_access(KIND_PAL, 0, SIZE_BYTE, 0, 8'd255);
    send_access(KIND_WRITE, WindowBaseDef + 12'hFFE, SIZE_WORD, 32'hFFFF_FFFF, 0);
    send_access(KIND_READ, WindowBaseDef + 12'hFFF, SIZE_WORD, 0, 0);
    send_access(KIND_WRITE, WindowBaseDef - 1, SIZE_HALF, 32'hFFFF, 0);
    send_access(KIND_READ, WindowBaseDef + AreaBytes, SIZE_HALF, 0, 0);
    send_access(KIND_READ, 32'hFFFF_FFFF, SIZE_BYTE, 0, 0);
    send_access(KIND_NONE, 32'hFFFF_FFFF, SIZE_WIDE, 32'hFFFF_FFFF, 8'hFF);
    // Long receiver hold-off while the sender keeps offering
    hold_off = 300;
    for (int i = 0; i < 40; i++) send_random();
    // Random phases of idling
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 81; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 81; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      for (int i = 0; i < 110; i++) send_random();
      if (ph == 3) begin
        // Let every awaited item arrive before continuing
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("video_chipset_register_file_core_tb: clean");
    else $display("video_chipset_register_file_core_tb: errors");
    $finish;
  end
endmodule
